[src/svm_pkg.sv]
// ----------------------------------------------------------------------------
// svm_pkg: shared definitions for the square-wave voice mixer
// Command codes, reset values and the elaboration-time pitch increment maths.
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam int VOICE_COUNT_DEF = 16;
  localparam int PHASE_BITS_DEF  = 32;

  localparam int NOTE_W = 7;
  localparam int AMP_W  = 15;
  localparam int PCM_W  = 20;
  localparam int OUT_W  = 16;
  localparam int CMD_W  = 2;

  localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

  localparam logic [AMP_W-1:0] AMP_RESET = 15'd4000;

  localparam logic [63:0] RATE_DIVISOR = 64'd4410000000;
  localparam logic [63:0] BASE_HZ_X512 = 64'd7040;

  localparam logic [17:0] SEMITONE [12] = '{
    18'd100000, 18'd105946, 18'd112246, 18'd118921, 18'd125992, 18'd133484,
    18'd141421, 18'd149831, 18'd158740, 18'd168179, 18'd178180, 18'd188775
  };

  // Phase step per output sample for one note, rounded half up.  Only used
  // to build constant tables, never in datapath logic.
  function automatic logic [63:0] note_increment(input logic [NOTE_W-1:0] n,
                                                 input int phase_bits);
    int          semi;
    int          oct;
    logic [127:0] num;
    logic [127:0] quo;
    semi = int'(n) % 12;
    oct  = int'(n) / 12;
    num  = 128'(BASE_HZ_X512 * 64'(SEMITONE[semi]));
    num  = num << (phase_bits + oct - 9);
    quo  = num / 128'(RATE_DIVISOR);
    quo  = (quo + 128'd1) >> 1;
    return quo[63:0];
  endfunction

endpackage

[src/svm_ram.sv]
// ----------------------------------------------------------------------------
// svm_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module svm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[src/square_wave_voice_mixer.sv]
// ----------------------------------------------------------------------------
// square_wave_voice_mixer: polyphonic square-wave synthesiser and mixer
// Note-on/off voice allocation and per-tick mixing with saturation.
// ----------------------------------------------------------------------------
// The input stream carries one command per beat: in_tuser selects note-on,
// note-off or sample tick, and in_tdata holds the note, the music-on flag and
// the sound-effect addend.  Only a tick produces an output beat, which carries
// the saturated 16-bit mixed sample.  The user must set the voice level through
// cfg_wr_en/cfg_wr_data while the block is idle; the block does not enforce it.
// The block handles one command at a time; in_tready is high only while the
// sequencer is idle.  A note-on walks the busy flags one voice per cycle
// until it claims a free voice or reaches the last one.  A note-off walks
// the voice RAM.  A tick with music on walks the RAM, then runs a restoring
// divider one quotient bit per cycle, after a first step that loads the
// magnitude, when more than one voice sounds, and then mixes and loads the
// output register.  A tick with music off goes straight to the mix step.
// Each command also spends the cycle in which it is accepted in the idle
// state.
// The output register decouples the sides: a finished sample waits there
// while the next command is accepted; only a further sample has to wait in
// the mix step until the receiver takes the previous one.
// Reset clears every voice to free and the voice level to 4000; the voice
// RAM needs no clearing because a voice's entry is written when it starts.
// ----------------------------------------------------------------------------
module square_wave_voice_mixer #(
  parameter int VOICE_COUNT = svm_pkg::VOICE_COUNT_DEF,
  parameter int PHASE_BITS  = svm_pkg::PHASE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Command stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // note[6:0], music_on[7], pcm_sum[27:8], zero pad
  input  logic [1:0]  in_tuser,   // command[1:0]
  // Sample stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // sample_out[15:0]
  // Voice level register.
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data
);

  localparam int NOTE_W = svm_pkg::NOTE_W;
  localparam int PCM_W  = svm_pkg::PCM_W;
  localparam int IDX_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int CNT_W  = $clog2(VOICE_COUNT + 1);
  // Largest voice sum is VOICE_COUNT * 32767, held as a magnitude.
  localparam int MAG_W  = svm_pkg::AMP_W + $clog2(VOICE_COUNT);
  localparam int ACC_W  = MAG_W + 1;
  localparam int SUM_W  = ((ACC_W > PCM_W) ? ACC_W : PCM_W) + 1;
  localparam int DB_W   = $clog2(MAG_W + 1);
  localparam int RAM_W  = NOTE_W + PHASE_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICE_COUNT - 1);

  // Phase step for every note, built at elaboration.
  function automatic logic [128*PHASE_BITS-1:0] build_inc_table();
    logic [128*PHASE_BITS-1:0] t;
    logic [63:0]               inc;
    t = '0;
    for (int i = 0; i < 128; i++) begin
      inc = svm_pkg::note_increment(NOTE_W'(i), PHASE_BITS);
      t[i*PHASE_BITS +: PHASE_BITS] = inc[PHASE_BITS-1:0];
    end
    return t;
  endfunction

  localparam logic [128*PHASE_BITS-1:0] INC_TABLE = build_inc_table();

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ON,
    ST_SCAN,
    ST_DIV,
    ST_MIX
  } state_t;

  state_t                   state_r, state_nxt;
  logic [svm_pkg::AMP_W-1:0] amp_r;
  logic [VOICE_COUNT-1:0]   busy_r, busy_nxt;
  logic [1:0]               cmd_r, cmd_nxt;
  logic [NOTE_W-1:0]        note_r, note_nxt;
  logic                     music_r, music_nxt;
  logic signed [PCM_W-1:0]  pcm_r, pcm_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [IDX_W-1:0]         proc_idx_r, proc_idx_nxt;
  logic                     iss_done_r, iss_done_nxt;
  logic                     rd_pend_r, rd_pend_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     neg_r, neg_nxt;
  logic [MAG_W-1:0]         quo_r, quo_nxt;
  logic [CNT_W-1:0]         rem_r, rem_nxt;
  logic [DB_W-1:0]          bit_r, bit_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [15:0]              out_data_r, out_data_nxt;

  // Voice RAM: note in the upper bits, phase accumulator below.
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [RAM_W-1:0]         ram_wdata;
  logic [IDX_W-1:0]         ram_raddr;
  logic [RAM_W-1:0]         ram_rdata;

  svm_ram #(
    .WIDTH (RAM_W),
    .DEPTH (VOICE_COUNT)
  ) u_voice_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  logic [NOTE_W-1:0]       rd_note;
  logic [PHASE_BITS-1:0]   rd_phase;
  logic [PHASE_BITS-1:0]   new_phase;
  logic signed [ACC_W-1:0] amp_ext;
  logic [MAG_W-1:0]        acc_mag;
  logic [CNT_W:0]          rem_sh;
  logic signed [SUM_W-1:0] mix_sum;
  logic                    in_fire;
  logic                    out_free;

  assign rd_note   = ram_rdata[PHASE_BITS +: NOTE_W];
  assign rd_phase  = ram_rdata[PHASE_BITS-1:0];
  assign new_phase = rd_phase + INC_TABLE[int'(rd_note) * PHASE_BITS +: PHASE_BITS];
  assign amp_ext   = ACC_W'($signed({1'b0, amp_r}));
  assign acc_mag   = acc_r[ACC_W-1] ? MAG_W'(-acc_r) : MAG_W'(acc_r);
  assign rem_sh    = {rem_r, quo_r[MAG_W-1]};
  assign mix_sum   = SUM_W'(acc_r) + SUM_W'(pcm_r);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    cmd_nxt       = cmd_r;
    note_nxt      = note_r;
    music_nxt     = music_r;
    pcm_nxt       = pcm_r;
    idx_nxt       = idx_r;
    proc_idx_nxt  = proc_idx_r;
    iss_done_nxt  = iss_done_r;
    rd_pend_nxt   = 1'b0;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = {note_r, {PHASE_BITS{1'b0}}};
    ram_raddr     = idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt      = in_tuser;
          note_nxt     = in_tdata[6:0];
          music_nxt    = in_tdata[7];
          pcm_nxt      = in_tdata[27:8];
          idx_nxt      = '0;
          iss_done_nxt = 1'b0;
          acc_nxt      = '0;
          cnt_nxt      = '0;
          case (in_tuser)
            svm_pkg::CMD_NOTE_ON:  state_nxt = ST_ON;
            svm_pkg::CMD_NOTE_OFF: state_nxt = ST_SCAN;
            svm_pkg::CMD_TICK:     state_nxt = in_tdata[7] ? ST_SCAN : ST_MIX;
            default:               state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_ON: begin
        // Claim the lowest free voice; drop the note when all are busy.
        if (!busy_r[idx_r]) begin
          busy_nxt[idx_r] = 1'b1;
          ram_we          = 1'b1;
          state_nxt       = ST_IDLE;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      ST_SCAN: begin
        // Read voice idx_r while the previous voice's data is processed.
        if (!iss_done_r) begin
          rd_pend_nxt  = 1'b1;
          proc_idx_nxt = idx_r;
          if (idx_r == LAST_IDX) begin
            iss_done_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
        ram_waddr = proc_idx_r;
        ram_wdata = {rd_note, new_phase};
        if (rd_pend_r && busy_r[proc_idx_r]) begin
          if (cmd_r == svm_pkg::CMD_NOTE_OFF) begin
            if (rd_note == note_r) begin
              busy_nxt[proc_idx_r] = 1'b0;
            end
          end else begin
            ram_we  = 1'b1;
            acc_nxt = new_phase[PHASE_BITS-1] ? (acc_r - amp_ext) : (acc_r + amp_ext);
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        if (rd_pend_r && iss_done_r) begin
          if (cmd_r == svm_pkg::CMD_NOTE_OFF) begin
            state_nxt = ST_IDLE;
          end else if (cnt_nxt > CNT_W'(1)) begin
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_MIX;
          end
        end
      end

      ST_DIV: begin
        // Restoring division of |acc| by the voice count, one bit a cycle.
        if (bit_r == '0) begin
          neg_nxt = acc_r[ACC_W-1];
          quo_nxt = acc_mag;
          rem_nxt = '0;
          bit_nxt = DB_W'(1);
        end else begin
          if (rem_sh >= {1'b0, cnt_r}) begin
            rem_nxt = CNT_W'(rem_sh - {1'b0, cnt_r});
            quo_nxt = {quo_r[MAG_W-2:0], 1'b1};
          end else begin
            rem_nxt = rem_sh[CNT_W-1:0];
            quo_nxt = {quo_r[MAG_W-2:0], 1'b0};
          end
          if (bit_r == DB_W'(MAG_W)) begin
            bit_nxt   = '0;
            acc_nxt   = neg_r ? -ACC_W'($signed({1'b0, quo_nxt}))
                              :  ACC_W'($signed({1'b0, quo_nxt}));
            state_nxt = ST_MIX;
          end else begin
            bit_nxt = bit_r + DB_W'(1);
          end
        end
      end

      ST_MIX: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (mix_sum > SUM_W'(32767)) begin
            out_data_nxt = 16'h7FFF;
          end else if (mix_sum < -SUM_W'(32768)) begin
            out_data_nxt = 16'h8000;
          end else begin
            out_data_nxt = mix_sum[15:0];
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= '0;
      amp_r       <= svm_pkg::AMP_RESET;
      iss_done_r  <= 1'b0;
      rd_pend_r   <= 1'b0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      iss_done_r  <= iss_done_nxt;
      rd_pend_r   <= rd_pend_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        amp_r <= cfg_wr_data;
      end
    end
    cmd_r      <= cmd_nxt;
    note_r     <= note_nxt;
    music_r    <= music_nxt;
    pcm_r      <= pcm_nxt;
    idx_r      <= idx_nxt;
    proc_idx_r <= proc_idx_nxt;
    acc_r      <= acc_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // The divider only runs when more than one voice sounds.
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r > CNT_W'(1)))
    else $error("divider running with voice count below two");

  // The voice RAM is written only by a note-on or by a tick with music on.
  a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == ST_ON) ||
                ((state_r == ST_SCAN) && (cmd_r == svm_pkg::CMD_TICK) && music_r)))
    else $error("voice RAM written outside a note-on or a sounding tick");

  // A new output beat only appears straight after the mix step.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_MIX))
    else $error("output beat raised outside the mix step");
`endif

endmodule

[tb/sv/svm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_checker: sample predictor and scoreboard for the voice mixer
// Follows every accepted command beat and level write, keeps its own voice
// state and compares each output sample beat with the oldest predicted one.
// ----------------------------------------------------------------------------
module svm_checker #(
  parameter int VOICES  = svm_pkg::VOICE_COUNT_DEF,
  parameter int PHASE_W = svm_pkg::PHASE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // note[6:0], music_on[7], pcm_sum[27:8], zero pad
  input  logic [1:0]  in_tuser,   // command[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // sample_out[15:0]
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,
  output int          fail_count,
  output int          pending
);

  localparam int REPORT_LIMIT = 10;

  // Semitone ratios scaled by 100000.
  localparam logic [17:0] RATIO [12] = '{
    18'd100000, 18'd105946, 18'd112246, 18'd118921, 18'd125992, 18'd133484,
    18'd141421, 18'd149831, 18'd158740, 18'd168179, 18'd178180, 18'd188775
  };

  logic               busy   [VOICES];
  logic [6:0]         vnote  [VOICES];
  logic [PHASE_W-1:0] vphase [VOICES];
  logic [PHASE_W-1:0] pitch_step [128];
  logic [14:0]        level;
  logic [15:0]        samples_due [$];

  // Phase advance per 44.1 kHz sample, rounded half up.
  function automatic logic [PHASE_W-1:0] pitch_step_of(input int n);
    int           semi;
    int           oct;
    logic [127:0] acc;
    semi = n % 12;
    oct  = n / 12;
    acc  = 128'(64'd7040 * 64'(RATIO[semi]));
    acc  = (acc << (PHASE_W + oct - 9)) / 128'd4410000000;
    return PHASE_W'((acc + 128'd1) >> 1);
  endfunction

  function automatic void start_voice(input logic [6:0] n);
    for (int v = 0; v < VOICES; v++) begin
      if (!busy[v]) begin
        busy[v]   = 1'b1;
        vnote[v]  = n;
        vphase[v] = '0;
        break;
      end
    end
  endfunction

  function automatic void stop_note(input logic [6:0] n);
    for (int v = 0; v < VOICES; v++)
      if (busy[v] && vnote[v] == n)
        busy[v] = 1'b0;
  endfunction

  function automatic logic [15:0] mix_tick(input logic music, input logic signed [19:0] pcm);
    int total;
    int sounding;
    total    = 0;
    sounding = 0;
    if (music) begin
      for (int v = 0; v < VOICES; v++) begin
        if (busy[v]) begin
          vphase[v] = vphase[v] + pitch_step[vnote[v]];
          if (vphase[v][PHASE_W-1])
            total -= int'(level);
          else
            total += int'(level);
          sounding++;
        end
      end
      // Integer division truncates toward zero, as the mixer does.
      if (sounding > 1)
        total = total / sounding;
    end
    total += int'(pcm);
    if (total > 32767)
      total = 32767;
    if (total < -32768)
      total = -32768;
    return 16'(total);
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    for (int n = 0; n < 128; n++)
      pitch_step[n] = pitch_step_of(n);
  end

  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst_n) begin
      level = svm_pkg::AMP_RESET;
      for (int v = 0; v < VOICES; v++) begin
        busy[v]   = 1'b0;
        vnote[v]  = '0;
        vphase[v] = '0;
      end
      samples_due.delete();
    end else begin
      if (cfg_wr_en)
        level = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          svm_pkg::CMD_NOTE_ON:  start_voice(in_tdata[6:0]);
          svm_pkg::CMD_NOTE_OFF: stop_note(in_tdata[6:0]);
          svm_pkg::CMD_TICK:
            samples_due.push_back(mix_tick(in_tdata[7], in_tdata[27:8]));
          default:               ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (samples_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("[%0t] sample beat %0d arrived with none predicted",
                     $time, $signed(out_tdata));
        end else begin
          want = samples_due.pop_front();
          if (out_tdata !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("[%0t] sample_out mismatch: expected %0d, got %0d",
                       $time, $signed(want), $signed(out_tdata));
          end
        end
      end
    end
    pending = samples_due.size();
  end

endmodule

[tb/sv/tb_square_wave_voice_mixer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_square_wave_voice_mixer: testbench top for the square-wave voice mixer
// Drives directed and random command beats under several voice levels, with
// random idling on both streams, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_square_wave_voice_mixer;

  // Command code the block must ignore without producing a sample.
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  // Long enough to cover any command, such as a note-on, still in flight
  // once the last sample has left.
  localparam int          IDLE_GUARD  = 64;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          PHASES      = 6;
  localparam int          PHASE_BEATS = 250;
  localparam logic [19:0] PCM_MAX     = 20'h7FFFF;
  localparam logic [19:0] PCM_MIN     = 20'h80000;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata    = '0;   // note[6:0], music_on[7], pcm_sum[27:8], zero pad
  logic [1:0]  in_tuser    = '0;   // command[1:0]
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;          // sample_out[15:0]
  logic        cfg_wr_en   = 1'b0;
  logic [14:0] cfg_wr_data = '0;

  int fail_count;
  int pending;
  int cycles     = 0;
  int stall_left = 0;
  // When set, neither side idles: used for the closing part of the run.
  bit quiet      = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  square_wave_voice_mixer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  svm_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // Watchdog: a hung handshake must not leave the run spinning for ever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Sample receiver. It drops out_tready in random bursts so that samples
  // wait in the output register and in the mix step; outside the quiet part
  // and out of reset, a burst starts with odds of one in five.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && rst_n && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Sound-effect addend: mostly modest values, some across the whole 20-bit
  // range, and some pinned at the extremes so that saturation is common.
  function automatic logic [19:0] rand_pcm();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      return 20'($urandom_range(0, 8191) - 4096);
    if (pick < 85)
      return 20'($urandom());
    if (pick < 92)
      return (pick[0]) ? PCM_MAX : PCM_MIN;
    return 20'($urandom_range(0, 65535) - 32768);
  endfunction

  // Presents one command beat and returns at the edge that accepts it.
  // A random gap with tvalid low may be inserted first. tvalid is never
  // lowered and raised in the same time step.
  task automatic send_beat(input logic [1:0] cmd, input logic [6:0] note,
                           input logic music, input logic [19:0] pcm);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0000, pcm, music, note};
    do @(posedge clk); while (!in_tready);
  endtask

  // Holds the command stream until every predicted sample has been taken,
  // then lets a note-on or note-off that produces no sample finish as well.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IDLE_GUARD) @(posedge clk);
  endtask

  // Level writes only ever happen while the block is idle.
  task automatic set_level(input logic [14:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // One random phase. Notes mostly come from a small pool so that note-offs
  // hit live voices and several voices share a note. The phase alternates
  // between filling the voices (allocation and the full-house drop) and
  // draining them, with ticks in between. Ignored commands are sprinkled in
  // but are not counted.
  task automatic run_phase(input int beats);
    logic [6:0]  pool [6];
    logic [6:0]  note;
    logic [19:0] pcm;
    logic        music;
    int          done;
    int          pick;
    int          on_pct;
    int          off_pct;
    bit          filling;
    done    = 0;
    filling = 1'b1;
    for (int i = 0; i < 6; i++)
      pool[i] = 7'($urandom_range(0, 127));
    while (done < beats) begin
      pick  = $urandom_range(0, 99);
      note  = ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, 5)]
                                           : 7'($urandom_range(0, 127));
      music = ($urandom_range(0, 6) != 0);
      pcm   = rand_pcm();
      if (pick < 2) begin
        send_beat(CMD_UNUSED, note, music, pcm);
        continue;
      end
      on_pct  = filling ? 45 : 12;
      off_pct = filling ? 8 : 35;
      if (pick < 2 + on_pct)
        send_beat(svm_pkg::CMD_NOTE_ON, note, music, pcm);
      else if (pick < 2 + on_pct + off_pct)
        send_beat(svm_pkg::CMD_NOTE_OFF, note, music, pcm);
      else
        send_beat(svm_pkg::CMD_TICK, note, music, pcm);
      done++;
      if (done % 40 == 0)
        filling = !filling;
    end
  endtask

  initial begin
    logic [14:0] level;

    // Hold reset, then release it on a clock edge.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset voice level. Ticks with no voices and with
    // music off must give the addend alone, saturated at both ends.
    send_beat(svm_pkg::CMD_TICK, 7'd0, 1'b1, 20'd0);
    send_beat(svm_pkg::CMD_TICK, 7'd0, 1'b0, PCM_MAX);
    send_beat(svm_pkg::CMD_TICK, 7'd127, 1'b1, PCM_MIN);
    // Lowest and highest notes; then a tick with music on and one with music
    // off, which must hold both phases.
    send_beat(svm_pkg::CMD_NOTE_ON, 7'd0, 1'b0, 20'd0);
    send_beat(svm_pkg::CMD_NOTE_ON, 7'd127, 1'b0, 20'd0);
    send_beat(svm_pkg::CMD_TICK, 7'd0, 1'b1, 20'd100);
    send_beat(svm_pkg::CMD_TICK, 7'd0, 1'b0, 20'hFFFFB);
    send_beat(svm_pkg::CMD_NOTE_OFF, 7'd0, 1'b0, 20'd0);
    // The unused command code must change nothing and emit nothing.
    send_beat(CMD_UNUSED, 7'd127, 1'b1, PCM_MAX);
    send_beat(svm_pkg::CMD_TICK, 7'd0, 1'b1, 20'd0);
    // Fill the remaining voices with one note; the note-on after that finds
    // no free voice and must be dropped.
    repeat (15) send_beat(svm_pkg::CMD_NOTE_ON, 7'd60, 1'b0, 20'd0);
    send_beat(svm_pkg::CMD_NOTE_ON, 7'd61, 1'b0, 20'd0);
    send_beat(svm_pkg::CMD_TICK, 7'd0, 1'b1, PCM_MAX);
    // One note-off frees all fifteen voices sharing that note.
    send_beat(svm_pkg::CMD_NOTE_OFF, 7'd60, 1'b0, 20'd0);
    send_beat(svm_pkg::CMD_TICK, 7'd0, 1'b1, PCM_MIN);

    // Random phases, each under its own voice level, with silence, the
    // largest level and the smallest non-zero level among them. The last
    // phase runs with no idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0:       level = 15'd0;
        1:       level = 15'd32767;
        2:       level = 15'd1;
        5:       level = 15'd32767;
        default: level = 15'($urandom_range(0, 32767));
      endcase
      set_level(level);
      quiet = (p == PHASES - 1);
      run_phase(PHASE_BEATS);
    end

    wait_idle();
    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
